[design/io_request_rule_classifier_top_defines.svh]
// Assertion macros shared by the request classifier RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef IO_REQUEST_RULE_CLASSIFIER_TOP_DEFINES_SVH
`define IO_REQUEST_RULE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define IORC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("iorc check failed");
// Checked at every clock edge, reset included.
`define IORC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("iorc check failed");
`else
`define IORC_ASSERT(name, clk, rst, prop)
`define IORC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[design/iorc_pkg.sv]
// Shared types and constants of the request rule classifier.
// No dependencies; used by the condition unit and the top level of the block.
package iorc_pkg;

   localparam int NUM_CLASSES_DEF    = 32;
   localparam int CONDS_PER_RULE_DEF = 8;

   localparam int CLASS_INDEX_W = 5;
   localparam int COND_SLOT_W   = 3;
   localparam int VALUE_W       = 64;
   localparam int CLASS_ID_W    = 5;

   typedef enum logic [0:0] {
      FUNC_WRITE,
      FUNC_CLASSIFY
   } func_type;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_RUNNING,
      KIND_ADDRESS,
      KIND_LENGTH
   } kind_type;

   typedef enum logic [2:0] {
      CMP_EQ,
      CMP_NE,
      CMP_LT,
      CMP_GT,
      CMP_LE,
      CMP_GE
   } cmp_type;

   // Stored control word of one condition slot
   typedef struct packed {
      logic     and_join;
      cmp_type  cmp_op;
      kind_type kind;
      logic     valid;
   } cond_ctl_type;

   localparam int CTL_W = $bits(cond_ctl_type);

   typedef struct packed {
      logic match;
      logic is_done;
   } cond_result_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_PUSH
   } state_type;

endpackage

[design/iorc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module iorc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/iorc_cond_unit.sv]
// Shared condition unit: selects the tested quantity and runs the 64-bit compare.
// Depends on iorc_pkg for the control word and result types.
module iorc_cond_unit (
   input  iorc_pkg::cond_ctl_type    ctl,
   input  logic [iorc_pkg::VALUE_W-1:0] cond_value,
   input  logic [iorc_pkg::VALUE_W-1:0] running,
   input  logic [iorc_pkg::VALUE_W-1:0] address,
   input  logic [iorc_pkg::VALUE_W-1:0] length,
   output iorc_pkg::cond_result_type res
);

   logic [iorc_pkg::VALUE_W-1:0] operand;
   logic                         cmp_true;

   always_comb begin
      case (ctl.kind)
         iorc_pkg::KIND_RUNNING: operand = running;
         iorc_pkg::KIND_ADDRESS: operand = address;
         iorc_pkg::KIND_LENGTH:  operand = length;
         default:                operand = '0;
      endcase
   end

   always_comb begin
      case (ctl.cmp_op)
         iorc_pkg::CMP_EQ: cmp_true = (operand == cond_value);
         iorc_pkg::CMP_NE: cmp_true = (operand != cond_value);
         iorc_pkg::CMP_LT: cmp_true = (operand <  cond_value);
         iorc_pkg::CMP_GT: cmp_true = (operand >  cond_value);
         iorc_pkg::CMP_LE: cmp_true = (operand <= cond_value);
         iorc_pkg::CMP_GE: cmp_true = (operand >= cond_value);
         default:          cmp_true = 1'b0;
      endcase
   end

   // A done condition always matches and ignores its compare
   always_comb begin
      res.is_done = (ctl.kind == iorc_pkg::KIND_DONE);
      res.match   = res.is_done | cmp_true;
   end

endmodule

[design/io_request_rule_classifier_top.sv]
// Storage request classifier: condition table walk under a small sequencer.
// Depends on iorc_pkg, iorc_ram, iorc_cond_unit and the assertion macro header.
//
// Usage:
//  - Input channel req_*: req_func selects a table write (one condition slot)
//    or a classify item (req_address, req_length).
//  - Result channel rsp_*: one item per classify item, rsp_class_id and
//    rsp_stopped_by_done; writes give no result.
//  - A classify item walks the table one condition slot per cycle through a
//    single shared compare unit fed by the table RAM's registered read port,
//    visiting at most (NUM_CLASSES-1) * CONDS_PER_RULE slots (248 by default);
//    a rule ends at its first empty slot or a failed and-join, the walk at a
//    done condition or after the last class.
//  - req_stall stays high while an item is walked; writes run back to back.
//  - The result sits in an output register; a stalled receiver holds it and
//    the block still takes the next item, blocking only the next result.
//  - After reset a clearing pass writes all NUM_CLASSES * CONDS_PER_RULE
//    control slots (256 by default) to empty, one entry per cycle, with
//    req_stall high.
`include "io_request_rule_classifier_top_defines.svh"

module io_request_rule_classifier_top #(
   parameter int NUM_CLASSES    = iorc_pkg::NUM_CLASSES_DEF,
   parameter int CONDS_PER_RULE = iorc_pkg::CONDS_PER_RULE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [iorc_pkg::CLASS_INDEX_W-1:0]  req_class_index,
   input  logic [iorc_pkg::COND_SLOT_W-1:0]    req_cond_slot,
   input  logic                                req_cond_valid,
   input  logic [1:0]                          req_cond_kind,
   input  logic [2:0]                          req_cond_compare,
   input  logic                                req_cond_join,
   input  logic [iorc_pkg::VALUE_W-1:0]        req_cond_value,
   input  logic [iorc_pkg::VALUE_W-1:0]        req_address,
   input  logic [iorc_pkg::VALUE_W-1:0]        req_length,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [iorc_pkg::CLASS_ID_W-1:0]     rsp_class_id,
   output logic                                rsp_stopped_by_done
);

   localparam int DEPTH  = NUM_CLASSES * CONDS_PER_RULE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CLS_W  = $clog2(NUM_CLASSES);
   localparam int SLOT_W = (CONDS_PER_RULE > 1) ? $clog2(CONDS_PER_RULE) : 1;

   iorc_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic               yes_ff, yes_in;
   logic [CLS_W-1:0]   running_ff, running_in;
   logic               stop_ff, stop_in;
   logic [iorc_pkg::VALUE_W-1:0] addr_ff, addr_in;
   logic [iorc_pkg::VALUE_W-1:0] len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [iorc_pkg::CLASS_ID_W-1:0] rsp_class_id_ff, rsp_class_id_in;
   logic               rsp_stopped_ff, rsp_stopped_in;

   logic               req_accept;
   logic               is_classify;
   logic               wr_ok;
   logic               item_wr;
   logic               load_rsp;
   logic [ADDR_W-1:0]  item_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               ctl_we;
   logic [ADDR_W-1:0]  ctl_waddr;
   iorc_pkg::cond_ctl_type ctl_wdata;
   iorc_pkg::cond_ctl_type item_ctl;
   logic [iorc_pkg::CTL_W-1:0] ctl_rd_raw;
   iorc_pkg::cond_ctl_type ctl_rd;
   logic [iorc_pkg::VALUE_W-1:0] value_rd;
   iorc_pkg::cond_result_type cond_res;

   logic               is_and;
   logic               rule_cut;
   logic               yes_next;
   logic               hit_done;
   logic               last_slot;
   logic               last_class;
   logic               rule_over;
   logic               rule_yes;
   logic               walk_over;
   logic [ADDR_W-1:0]  walk_addr_next;

   // Item decode and table write port
   assign req_accept  = req_valid && !req_stall;
   assign is_classify = (iorc_pkg::func_type'(req_func) == iorc_pkg::FUNC_CLASSIFY);
   assign wr_ok       = (req_class_index != '0)
                     && (int'(req_class_index) < NUM_CLASSES)
                     && (int'(req_cond_slot) < CONDS_PER_RULE);
   assign item_wr     = req_accept && !is_classify && wr_ok;
   assign item_addr   = ADDR_W'(int'(req_class_index) * CONDS_PER_RULE
                                + int'(req_cond_slot));

   always_comb begin
      item_ctl.and_join = req_cond_join;
      item_ctl.cmp_op   = iorc_pkg::cmp_type'(req_cond_compare);
      item_ctl.kind     = iorc_pkg::kind_type'(req_cond_kind);
      item_ctl.valid    = req_cond_valid;
   end

   // The clearing pass owns the control write port until it is done
   always_comb begin
      if (state_ff == iorc_pkg::ST_CLEAR) begin
         ctl_we    = 1'b1;
         ctl_waddr = clr_cnt_ff;
         ctl_wdata = '0;
      end else begin
         ctl_we    = item_wr;
         ctl_waddr = item_addr;
         ctl_wdata = item_ctl;
      end
   end

   iorc_ram #(
      .WIDTH (iorc_pkg::CTL_W),
      .DEPTH (DEPTH)
   ) u_ctl_ram (
      .clock   (clock),
      .wr_en   (ctl_we),
      .wr_addr (ctl_waddr),
      .wr_data (ctl_wdata),
      .rd_addr (rd_addr),
      .rd_data (ctl_rd_raw)
   );

   iorc_ram #(
      .WIDTH (iorc_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (item_wr),
      .wr_addr (item_addr),
      .wr_data (req_cond_value),
      .rd_addr (rd_addr),
      .rd_data (value_rd)
   );

   assign ctl_rd = iorc_pkg::cond_ctl_type'(ctl_rd_raw);

   iorc_cond_unit u_cond_unit (
      .ctl        (ctl_rd),
      .cond_value (value_rd),
      .running    (iorc_pkg::VALUE_W'(running_ff)),
      .address    (addr_ff),
      .length     (len_ff),
      .res        (cond_res)
   );

   // Rule evaluation of the slot whose data the RAM presents this cycle
   always_comb begin
      is_and     = (slot_ff != '0) && ctl_rd.and_join;
      rule_cut   = !ctl_rd.valid || (!yes_ff && is_and);
      yes_next   = is_and ? (cond_res.match && yes_ff) : (cond_res.match || yes_ff);
      hit_done   = !rule_cut && cond_res.is_done;
      last_slot  = (slot_ff == SLOT_W'(CONDS_PER_RULE - 1));
      last_class = (cls_ff == CLS_W'(NUM_CLASSES - 1));
      rule_over  = rule_cut || hit_done || last_slot;
      rule_yes   = rule_cut ? yes_ff : yes_next;
      walk_over  = rule_over && (hit_done || last_class);
      if (rule_over) begin
         walk_addr_next = base_ff + ADDR_W'(CONDS_PER_RULE);
      end else begin
         walk_addr_next = base_ff + ADDR_W'(slot_ff) + ADDR_W'(1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iorc_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = iorc_pkg::ST_IDLE;
            end
         end
         iorc_pkg::ST_IDLE: begin
            if (req_accept && is_classify) begin
               state_in = iorc_pkg::ST_WALK;
            end
         end
         iorc_pkg::ST_WALK: begin
            if (walk_over) begin
               state_in = iorc_pkg::ST_PUSH;
            end
         end
         iorc_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = iorc_pkg::ST_IDLE;
            end
         end
         default: state_in = iorc_pkg::ST_CLEAR;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      rd_addr   = ADDR_W'(CONDS_PER_RULE);
      case (state_ff)
         iorc_pkg::ST_IDLE: req_stall = 1'b0;
         iorc_pkg::ST_WALK: rd_addr = walk_addr_next;
         iorc_pkg::ST_PUSH: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Walk counters and result register
   always_comb begin
      clr_cnt_in      = clr_cnt_ff;
      cls_in          = cls_ff;
      slot_in         = slot_ff;
      base_in         = base_ff;
      yes_in          = yes_ff;
      running_in      = running_ff;
      stop_in         = stop_ff;
      addr_in         = addr_ff;
      len_in          = len_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_class_id_in = rsp_class_id_ff;
      rsp_stopped_in  = rsp_stopped_ff;

      if (state_ff == iorc_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end

      if (state_ff == iorc_pkg::ST_IDLE && req_accept && is_classify) begin
         cls_in     = CLS_W'(1);
         slot_in    = '0;
         base_in    = ADDR_W'(CONDS_PER_RULE);
         yes_in     = 1'b0;
         running_in = '0;
         stop_in    = 1'b0;
         addr_in    = req_address;
         len_in     = req_length;
      end

      if (state_ff == iorc_pkg::ST_WALK) begin
         if (rule_over) begin
            if (rule_yes) begin
               running_in = cls_ff;
            end
            stop_in = hit_done;
            if (!walk_over) begin
               cls_in  = cls_ff + CLS_W'(1);
               slot_in = '0;
               base_in = base_ff + ADDR_W'(CONDS_PER_RULE);
               yes_in  = 1'b0;
            end
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
            yes_in  = yes_next;
         end
      end

      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_class_id_in = iorc_pkg::CLASS_ID_W'(running_ff);
         rsp_stopped_in  = stop_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iorc_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff          <= cls_in;
      slot_ff         <= slot_in;
      base_ff         <= base_in;
      yes_ff          <= yes_in;
      running_ff      <= running_in;
      stop_ff         <= stop_in;
      addr_ff         <= addr_in;
      len_ff          <= len_in;
      rsp_class_id_ff <= rsp_class_id_in;
      rsp_stopped_ff  <= rsp_stopped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_class_id        = rsp_class_id_ff;
   assign rsp_stopped_by_done = rsp_stopped_ff;

   `IORC_ASSERT(a_slot_in_range, clock, reset,
      (state_ff == iorc_pkg::ST_WALK) |-> (slot_ff <= SLOT_W'(CONDS_PER_RULE - 1)))
   `IORC_ASSERT(a_running_below_class, clock, reset,
      (state_ff == iorc_pkg::ST_WALK) |-> (running_ff < cls_ff))
   `IORC_ASSERT(a_done_sets_class, clock, reset,
      (state_ff == iorc_pkg::ST_PUSH && stop_ff) |-> (running_ff != '0))
   `IORC_ASSERT_ALWAYS(a_clear_covers_table, clock,
      (state_ff == iorc_pkg::ST_IDLE && $past(state_ff) == iorc_pkg::ST_CLEAR)
      |-> ($past(clr_cnt_ff) == ADDR_W'(DEPTH - 1)))

endmodule
